>>> rtl/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_INS_FRONT  = 2'd0,
        KIND_INS_REAR   = 2'd1,
        KIND_SRCH_FRONT = 2'd2,
        KIND_SRCH_REAR  = 2'd3
    } t_kind;

    // ring slot of base + offset, both below DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/bsd_ram.sv
`default_nettype none

module bsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/bidirectional_search_deque.sv
// Bounded deque of signed 32-bit values with linear search from either end.
// Input channel: i_valid / o_stall carrying i_kind and i_value. An item is
// taken at a clock edge with i_valid high and o_stall low.
//   kind 0 / 1 insert at the front / rear; kind 2 / 3 search from front / rear.
// Output channel: o_valid / i_stall carrying o_found, o_position, o_overflow.
// Every item gives exactly one result.
// Timing: an insert or a search of an empty store puts its result in the
// output register at the edge where the item is taken. A search reads one
// stored entry per cycle from the entry RAM (one read port, registered
// read) and stops at the first match. Its hit or miss goes from the done
// state into the output register once that register is free; the state
// then returns to idle, where the next item can be taken. One item is
// worked on at a time.
// A result waiting in the output register does not block the next item; the
// input stalls only while a search runs or while the output register is full
// and the receiver holds i_stall high.
// Reset (synchronous, i_rst_n low) empties the store and drops any pending
// result; stored values are not cleared.
`default_nettype none

module bidirectional_search_deque (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_kind,
    input  wire logic signed [31:0]          i_value,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_found,
    output logic      [bsd_pkg::CNT_W-1:0]   o_position,
    output logic                             o_overflow
);
    import bsd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_front, n_front;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [DATA_W-1:0]   r_key, n_key;
    logic                r_rear, n_rear;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic                r_cmp_valid, n_cmp_valid;
    logic [CNT_W-1:0]    r_cmp_j, n_cmp_j;
    logic                r_res_found, n_res_found;
    logic [CNT_W-1:0]    r_res_pos, n_res_pos;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [CNT_W-1:0]    r_out_pos, n_out_pos;
    logic                r_out_ovf, n_out_ovf;

    // write of an accepted insert, carried to the next cycle
    logic                r_pending_wr, n_pending_wr;
    logic [ADDR_W-1:0]   r_wr_addr, n_wr_addr;

    logic                out_free;
    logic                accept;
    logic                full;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr;
    logic [ADDR_W-1:0]   front_dec;
    logic [ADDR_W-1:0]   rd_off;
    logic [CNT_W-1:0]    rear_off;
    logic [DATA_W-1:0]   rdata;

    // writes occur only in idle and read data is used only while searching, so
    // accesses to the same entry never overlap
    bsd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_key),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign accept    = i_valid && (r_state == ST_IDLE) && out_free;
    assign o_stall   = !((r_state == ST_IDLE) && out_free);
    assign full      = (r_occ == CNT_W'(DEPTH));
    assign front_dec = (r_front == '0) ? ADDR_W'(DEPTH - 1) : r_front - ADDR_W'(1);
    assign rear_off  = r_occ - CNT_W'(1) - r_issue;
    assign rd_off    = r_rear ? rear_off[ADDR_W-1:0] : r_issue[ADDR_W-1:0];
    assign raddr     = wrap_add(r_front, rd_off);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_occ       = r_occ;
        n_key       = r_key;
        n_rear      = r_rear;
        n_issue     = r_issue;
        n_cmp_valid = r_cmp_valid;
        n_cmp_j     = r_cmp_j;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        n_out_ovf   = r_out_ovf;
        we          = 1'b0;
        waddr       = front_dec;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b0;
                    n_out_pos   = '0;
                    n_out_ovf   = 1'b0;
                    case (t_kind'(i_kind))
                        KIND_INS_FRONT: begin
                            if (full) begin
                                n_out_ovf = 1'b1;
                            end else begin
                                n_key   = i_value;
                                n_front = front_dec;
                                n_occ   = r_occ + CNT_W'(1);
                            end
                        end
                        KIND_INS_REAR: begin
                            if (full) begin
                                n_out_ovf = 1'b1;
                            end else begin
                                n_key = i_value;
                                n_occ = r_occ + CNT_W'(1);
                            end
                        end
                        KIND_SRCH_FRONT, KIND_SRCH_REAR: begin
                            // empty store: answer a miss at once
                            if (r_occ != '0) begin
                                n_out_valid = r_out_valid && i_stall;
                                n_key       = i_value;
                                n_rear      = i_kind[0];
                                n_issue     = '0;
                                n_cmp_valid = 1'b0;
                                n_state     = ST_SEARCH;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
                // the insert write lands in the cycle after the item is taken,
                // with the key register and updated indexes
                if (r_pending_wr) begin
                    we    = 1'b1;
                    waddr = r_wr_addr;
                end
            end
            ST_SEARCH: begin
                // issue one read per cycle, compare the one returned
                n_cmp_valid = (r_issue < r_occ);
                n_cmp_j     = r_issue;
                if (r_issue < r_occ) begin
                    n_issue = r_issue + CNT_W'(1);
                end
                if (r_cmp_valid) begin
                    if (rdata == r_key) begin
                        n_res_found = 1'b1;
                        n_res_pos   = r_cmp_j + CNT_W'(1);
                        n_cmp_valid = 1'b0;
                        n_state     = ST_DONE;
                    end else if (r_cmp_j == r_occ - CNT_W'(1)) begin
                        n_res_found = 1'b0;
                        n_res_pos   = '0;
                        n_cmp_valid = 1'b0;
                        n_state     = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_pos   = r_res_pos;
                    n_out_ovf   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_pending_wr = 1'b0;
        n_wr_addr    = r_wr_addr;
        if (accept && !full) begin
            if (t_kind'(i_kind) == KIND_INS_FRONT) begin
                n_pending_wr = 1'b1;
                n_wr_addr    = front_dec;
            end else if (t_kind'(i_kind) == KIND_INS_REAR) begin
                n_pending_wr = 1'b1;
                n_wr_addr    = wrap_add(r_front, r_occ[ADDR_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_front      <= '0;
            r_occ        <= '0;
            r_cmp_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pending_wr <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_front      <= n_front;
            r_occ        <= n_occ;
            r_cmp_valid  <= n_cmp_valid;
            r_out_valid  <= n_out_valid;
            r_pending_wr <= n_pending_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_rear      <= n_rear;
        r_issue     <= n_issue;
        r_cmp_j     <= n_cmp_j;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
        r_out_ovf   <= n_out_ovf;
        r_wr_addr   <= n_wr_addr;
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;
    assign o_overflow = r_out_ovf;

endmodule

`default_nettype wire

>>> rtl/bsd_checker.sv
`default_nettype none

module bsd_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      o_stall,
    input  wire logic [1:0]                i_kind,
    input  wire logic                      o_valid,
    input  wire logic                      i_stall,
    input  wire logic                      o_found,
    input  wire logic [bsd_pkg::CNT_W-1:0] o_position,
    input  wire logic                      o_overflow
);
    import bsd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found) && $stable(o_position)
                               && $stable(o_overflow))
        else $error("stalled result changed");

    a_hit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_position != '0 && o_position <= CNT_W'(DEPTH)
                               && !o_overflow)
        else $error("hit with bad position or overflow");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_position == '0)
        else $error("miss with nonzero position");

    // an insert answers at the next edge, never as a hit
    a_ins_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_kind[1] |=> o_valid && !o_found)
        else $error("insert result missing");

endmodule

bind bidirectional_search_deque bsd_checker u_bsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_kind     (i_kind),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_found    (o_found),
    .o_position (o_position),
    .o_overflow (o_overflow)
);

`default_nettype wire
